### hdl/assert_macros.svh
// Assertion macros for the RTL files; lqrm_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### hdl/lqrm_pkg.sv
// ----------------------------------------------------------------------------
// lqrm_pkg
// Shared types and constants of the lock queue revoke manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lqrm_pkg;
  localparam int NumClients = 16;
  localparam int NumLocks   = 64;
  localparam int QueueDepth = 16;
  localparam int CliW  = 4;
  localparam int LockW = 6;
  localparam int SlotW = 4;
  localparam int CntW  = 5;
  localparam int QtW   = SlotW + CntW;   // queue table entry: head, count
  localparam int StoreDepth = NumLocks * QueueDepth;
  localparam int StoreAw = LockW + SlotW;

  localparam logic [1:0] MSG_REPLY  = 2'd0;
  localparam logic [1:0] MSG_RETRY  = 2'd1;
  localparam logic [1:0] MSG_REVOKE = 2'd2;
  localparam logic KIND_ACQ = 1'b0;
  localparam logic KIND_REL = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [LockW-1:0]  lock_index;
    logic [CliW-1:0]   client;
    logic [31:0]       request_id;
  } req_t;

  // one output beat
  typedef struct packed {
    logic        last;
    logic [31:0] call_seq;
    logic [5:0]  msg_lock;
    logic [3:0]  target_client;
    logic        reply_status;
    logic [1:0]  msg_kind;
  } msg_t;
endpackage

### hdl/lqrm_ram.sv
// ----------------------------------------------------------------------------
// lqrm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lqrm_ram #(
  parameter int Width = 4,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/lqrm_front.sv
// ----------------------------------------------------------------------------
// lqrm_front
// Request intake: a two-entry queue that decouples intake from execution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lqrm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lqrm_pkg::req_t     in_req_i,
  output logic               req_valid_o,
  input  logic               req_pop_i,
  output lqrm_pkg::req_t     req_o
);
  lqrm_pkg::req_t buf_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wp_q <= ~wp_q;
      if (req_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, in_valid_i && in_ready_o} - {1'b0, req_pop_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) buf_q[wp_q] <= in_req_i;
  end
endmodule

### hdl/lqrm_back.sv
// ----------------------------------------------------------------------------
// lqrm_back
// Request execution: table lookups and updates, callback records, output beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lqrm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             is_primary_i,
  input  logic             req_valid_i,
  output logic             req_pop_o,
  input  lqrm_pkg::req_t   req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lqrm_pkg::msg_t   out_msg_o
);
  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FRONT, S_EMIT} state_e;
  state_e state_q;

  logic [31:0] acq_seen_q [lqrm_pkg::NumClients];
  logic        acq_stat_q [lqrm_pkg::NumClients];
  logic [31:0] rel_seen_q [lqrm_pkg::NumClients];
  logic [31:0] cbc_q      [lqrm_pkg::NumClients];

  logic [31:0] ry_req_q, ry_seq_q, rv_req_q, rv_seq_q;
  logic [lqrm_pkg::StoreAw-1:0] ry_dst_q, rv_dst_q;
  logic ry_val_q, rv_val_q;

  lqrm_pkg::req_t r_q;
  lqrm_pkg::msg_t msgs_q [3];
  logic [1:0] nmsg_q, idx_q;
  logic       flag_q;   // EXEC: front read needed (second waiter queued, or pop leaves a waiter)
  logic       two_q;    // release leaves more than one waiter: revoke too

  logic                         st_we;
  logic [lqrm_pkg::StoreAw-1:0] st_waddr, st_raddr;
  logic [lqrm_pkg::CliW-1:0]    st_rdata;

  lqrm_ram #(.Width(lqrm_pkg::CliW), .Depth(lqrm_pkg::StoreDepth)) u_store (
    .clk_i(clk_i), .we_i(st_we), .waddr_i(st_waddr), .wdata_i(r_q.client),
    .raddr_i(st_raddr), .rdata_o(st_rdata));

  // per-lock head and count; an entry reads as empty until first written
  logic                          qt_we;
  logic [lqrm_pkg::LockW-1:0]    qt_raddr;
  logic [lqrm_pkg::QtW-1:0]      qt_wdata, qt_rdata;
  logic [lqrm_pkg::NumLocks-1:0] qt_vld_q;

  logic [lqrm_pkg::LockW-1:0] lk;

  lqrm_ram #(.Width(lqrm_pkg::QtW), .Depth(lqrm_pkg::NumLocks)) u_qtab (
    .clk_i(clk_i), .we_i(qt_we), .waddr_i(lk), .wdata_i(qt_wdata),
    .raddr_i(qt_raddr), .rdata_o(qt_rdata));

  logic [lqrm_pkg::CliW-1:0]  cl;
  logic [lqrm_pkg::CntW-1:0]  qc;
  logic [lqrm_pkg::SlotW-1:0] qh, nh;
  logic acq_new, acq_push, rel_new, rel_pop;
  assign lk = r_q.lock_index;
  assign cl = r_q.client;
  // table read issued at the pop edge, data valid during EXEC
  assign qt_raddr = (state_q == S_IDLE) ? req_i.lock_index : lk;
  assign qc = qt_vld_q[lk] ? qt_rdata[lqrm_pkg::CntW-1:0] : '0;
  assign qh = qt_vld_q[lk] ? qt_rdata[lqrm_pkg::QtW-1:lqrm_pkg::CntW] : '0;
  assign nh = qh + lqrm_pkg::SlotW'(1);
  assign acq_new  = (r_q.kind == lqrm_pkg::KIND_ACQ) && (acq_seen_q[cl] < r_q.request_id);
  assign acq_push = acq_new && (qc < 5'(lqrm_pkg::QueueDepth));
  assign rel_new  = (r_q.kind == lqrm_pkg::KIND_REL) && (rel_seen_q[cl] < r_q.request_id);
  assign rel_pop  = rel_new && (qc != '0);

  assign qt_we    = (state_q == S_EXEC) && (acq_push || rel_pop);
  assign qt_wdata = rel_pop ? {nh, qc - 5'd1} : {qh, qc + 5'd1};

  assign st_we    = (state_q == S_EXEC) && acq_push;
  assign st_waddr = {lk, qh + qc[lqrm_pkg::SlotW-1:0]};
  // acquire needs the front when the queue turns two; release needs new head
  assign st_raddr = (r_q.kind == lqrm_pkg::KIND_ACQ) ? {lk, qh} : {lk, nh};

  assign req_pop_o   = (state_q == S_IDLE) && req_valid_i;
  assign out_valid_o = (state_q == S_EMIT);
  assign out_msg_o   = msgs_q[idx_q];

  function automatic lqrm_pkg::msg_t cb(logic [1:0] k, logic [31:0] s,
                                        logic [lqrm_pkg::StoreAw-1:0] d);
    lqrm_pkg::msg_t m;
    m = '0;
    m.msg_kind = k; m.call_seq = s;
    m.target_client = d[lqrm_pkg::CliW-1:0];
    m.msg_lock = d[lqrm_pkg::StoreAw-1:lqrm_pkg::CliW];
    return m;
  endfunction

  // message build after updates (S_FRONT sees the updated records)
  lqrm_pkg::msg_t mb [3];
  lqrm_pkg::msg_t rep;
  logic [1:0] nb;
  logic acq_eq, rel_eq, ry_hit, rv_hit;
  always_comb begin
    rep = '0;
    rep.last = 1'b1;
    rep.msg_kind = lqrm_pkg::MSG_REPLY;
    rep.target_client = r_q.client;
    rep.msg_lock = r_q.lock_index;
    acq_eq = (acq_seen_q[cl] == r_q.request_id);
    rel_eq = (rel_seen_q[cl] == r_q.request_id);
    ry_hit = ry_val_q && (ry_req_q == r_q.request_id);
    rv_hit = rv_val_q && (rv_req_q == r_q.request_id);
    mb[0] = rep; mb[1] = rep; mb[2] = rep;
    nb = 2'd1;
    if (r_q.kind == lqrm_pkg::KIND_ACQ) begin
      if (acq_eq) begin
        rep.reply_status = acq_stat_q[cl];
        mb[0] = rep; mb[1] = rep;
        if (rv_hit && is_primary_i) begin
          mb[0] = cb(lqrm_pkg::MSG_REVOKE, rv_seq_q, rv_dst_q);
          nb = 2'd2;
        end
      end
    end else if (rel_eq && is_primary_i) begin
      if (ry_hit && rv_hit) begin
        mb[0] = cb(lqrm_pkg::MSG_RETRY, ry_seq_q, ry_dst_q);
        mb[1] = cb(lqrm_pkg::MSG_REVOKE, rv_seq_q, rv_dst_q);
        nb = 2'd3;
      end else if (ry_hit) begin
        mb[0] = cb(lqrm_pkg::MSG_RETRY, ry_seq_q, ry_dst_q); nb = 2'd2;
      end else if (rv_hit) begin
        mb[0] = cb(lqrm_pkg::MSG_REVOKE, rv_seq_q, rv_dst_q); nb = 2'd2;
      end
    end
  end

  logic [lqrm_pkg::CliW-1:0] fr;
  assign fr = st_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q <= '0;
      for (int i = 0; i < lqrm_pkg::NumClients; i++) begin
        acq_seen_q[i] <= '0; acq_stat_q[i] <= 1'b0;
        rel_seen_q[i] <= '0; cbc_q[i] <= 32'd1;
      end
      qt_vld_q <= '0;
      ry_req_q <= '0; ry_seq_q <= '0; ry_dst_q <= '0; ry_val_q <= 1'b0;
      rv_req_q <= '0; rv_seq_q <= '0; rv_dst_q <= '0; rv_val_q <= 1'b0;
      nmsg_q <= '0; idx_q <= '0; flag_q <= 1'b0; two_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (req_valid_i) begin
          r_q <= req_i;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          flag_q <= (acq_push && (qc == 5'd1)) || (rel_pop && (qc > 5'd1));
          two_q  <= rel_pop && (qc > 5'd2);
          if (qt_we) qt_vld_q[lk] <= 1'b1;
          if (acq_new) begin
            acq_seen_q[cl] <= r_q.request_id;
            if (!acq_push) acq_stat_q[cl] <= 1'b1;
            else acq_stat_q[cl] <= (qc != '0);
          end
          if (rel_new) rel_seen_q[cl] <= r_q.request_id;
          state_q <= S_FRONT;
        end
        S_FRONT: begin
          // store read of the front (new head on release) has landed
          if (flag_q) begin
            if (r_q.kind == lqrm_pkg::KIND_ACQ) begin
              rv_req_q <= r_q.request_id; rv_seq_q <= cbc_q[fr];
              rv_dst_q <= {lk, fr}; rv_val_q <= 1'b1;
              cbc_q[fr] <= cbc_q[fr] + 32'd1;
            end else begin
              ry_req_q <= r_q.request_id; ry_seq_q <= cbc_q[fr];
              ry_dst_q <= {lk, fr}; ry_val_q <= 1'b1;
              if (two_q) begin
                rv_req_q <= r_q.request_id; rv_seq_q <= cbc_q[fr] + 32'd1;
                rv_dst_q <= {lk, fr}; rv_val_q <= 1'b1;
                cbc_q[fr] <= cbc_q[fr] + 32'd2;
              end else cbc_q[fr] <= cbc_q[fr] + 32'd1;
            end
          end
          flag_q <= 1'b0;
          state_q <= flag_q ? S_FRONT : S_EMIT;
          if (!flag_q) begin
            msgs_q <= mb; nmsg_q <= nb; idx_q <= '0;
          end
        end
        S_EMIT: if (out_ready_i) begin
          if (idx_q + 2'd1 == nmsg_q) begin
            state_q <= S_IDLE;
            idx_q <= '0;
          end else idx_q <= idx_q + 2'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_idx_range, clk_i, rst_ni, (state_q == S_EMIT) && (idx_q >= nmsg_q))
  `ASSERT_IMPL(a_last_end, clk_i, rst_ni,
    (out_valid_o && out_ready_i && out_msg_o.last) |=> (state_q == S_IDLE))
  `ASSERT_NEVER(a_cnt_over, clk_i, rst_ni, (state_q == S_EXEC) && (qc > 5'(lqrm_pkg::QueueDepth)))
endmodule

### hdl/lock_queue_revoke_manager_core.sv
// ----------------------------------------------------------------------------
// lock_queue_revoke_manager_core
// Caching lock server with revoke and retry callbacks.
// ----------------------------------------------------------------------------
// Use: requests (acquire/release) come in on the s_axis group, one beat each.
// Each request yields one to three m_axis beats: callbacks (retry, revoke)
// first, then the reply, which carries tlast; m_axis_tuser gives the beat's
// message kind. The is_primary register (cfg port) gates callbacks.
// A two-entry intake queue decouples the front from the executing back end,
// so a new request is taken while results of the previous one still wait.
// Flow: the back end pops a request in IDLE, looks up the queue table in EXEC,
// reads the waiting-client store's registered read port in FRONT (a second FRONT
// pass builds the messages when a callback record is made), then sends one beat
// per cycle in EMIT while the receiver is ready; one request is in flight at a time.
// Reset clears the per-client tables and records; per-lock queue entries read
// as empty until first written (one flag per lock), the waiting-client store
// needs no clear.
// A stalled receiver holds the back end; the intake fills and then drops ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lock_queue_revoke_manager_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // lock_index[5:0], client[9:6], request_id[41:10]
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // reply_status[0], target_client[4:1],
                                      // msg_lock[10:5], call_seq[42:11]
  output logic [1:0]  m_axis_tuser,   // msg_kind[1:0]
  output logic        m_axis_tlast
);
  logic prim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prim_q <= 1'b1;
    else if (cfg_we_i) prim_q <= cfg_wdata_i;
  end

  lqrm_pkg::req_t in_req, req;
  logic req_valid, req_pop;
  lqrm_pkg::msg_t msg;

  assign in_req.kind       = s_axis_tuser;
  assign in_req.lock_index = s_axis_tdata[5:0];
  assign in_req.client     = s_axis_tdata[9:6];
  assign in_req.request_id = s_axis_tdata[41:10];

  lqrm_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_req_i(in_req), .req_valid_o(req_valid), .req_pop_i(req_pop), .req_o(req));

  lqrm_back u_back (
    .clk_i, .rst_ni, .is_primary_i(prim_q), .req_valid_i(req_valid),
    .req_pop_o(req_pop), .req_i(req), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .out_msg_o(msg));

  assign m_axis_tdata = {5'b0, msg.call_seq, msg.msg_lock, msg.target_client,
                         msg.reply_status};
  assign m_axis_tuser = msg.msg_kind;
  assign m_axis_tlast = msg.last;
endmodule

### sim/lock_queue_revoke_manager_core_tb.sv
// ----------------------------------------------------------------------------
// lock_queue_revoke_manager_core_tb
// Self-checking bench for the caching lock server core: requests are driven
// on the slave stream, each result beat is checked against an in-bench model
// of the waiter queues, duplicate filters and callback records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lock_queue_revoke_manager_core_tb;
  localparam int CycleLimit = 200000;
  localparam int ExpDepth   = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  lock_queue_revoke_manager_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // mirrored server state
  logic                         primary_q;
  logic [31:0]                  acq_seen [lqrm_pkg::NumClients];
  logic                         acq_status [lqrm_pkg::NumClients];
  logic [31:0]                  rel_seen [lqrm_pkg::NumClients];
  logic [31:0]                  cb_count [lqrm_pkg::NumClients];
  logic [lqrm_pkg::CliW-1:0]    waiters [lqrm_pkg::NumLocks][lqrm_pkg::QueueDepth];
  logic [lqrm_pkg::SlotW-1:0]   q_head [lqrm_pkg::NumLocks];
  int                           q_count [lqrm_pkg::NumLocks];

  typedef struct {
    logic [31:0] req;
    logic [31:0] seq;
    logic [5:0]  lk;
    logic [3:0]  cl;
    logic        valid;
  } callback_rec_t;
  callback_rec_t retry_rec, revoke_rec;

  // expected beats, in order
  lqrm_pkg::msg_t exp_mem [ExpDepth];
  int             exp_wr = 0, exp_rd = 0;
  logic [31:0]    id_ctr [lqrm_pkg::NumClients];
  int             idle_pct = 0, stall_pct = 0;
  int             fails = 0, beats_seen = 0, reqs_sent = 0, cycles = 0;

  function automatic void push_msg(logic [1:0] mk, logic st, logic [3:0] tgt,
                                   logic [5:0] lk, logic [31:0] seq, logic fin);
    lqrm_pkg::msg_t m;
    m.msg_kind = mk; m.reply_status = st; m.target_client = tgt;
    m.msg_lock = lk; m.call_seq = seq; m.last = fin;
    exp_mem[exp_wr % ExpDepth] = m;
    exp_wr++;
  endfunction

  function automatic callback_rec_t new_callback(logic [31:0] req, logic [5:0] lk,
                                                 logic [3:0] cl);
    callback_rec_t r;
    r.req = req; r.seq = cb_count[cl]; r.lk = lk; r.cl = cl; r.valid = 1'b1;
    cb_count[cl] = cb_count[cl] + 32'd1;
    return r;
  endfunction

  function automatic void push_callback(logic [1:0] mk, callback_rec_t r);
    push_msg(mk, 1'b0, r.cl, r.lk, r.seq, 1'b0);
  endfunction

  // Works out the beats one request produces; callbacks first, reply last.
  function automatic void predict_request(logic kind, logic [5:0] lk, logic [3:0] cl,
                                          logic [31:0] id);
    logic st;
    logic [lqrm_pkg::SlotW-1:0] slot;
    st = 1'b0;
    if (kind == lqrm_pkg::KIND_ACQ) begin
      if (acq_seen[cl] < id) begin
        acq_seen[cl] = id;
        if (q_count[lk] >= lqrm_pkg::QueueDepth) begin
          acq_status[cl] = 1'b1;     // full queue: not queued
        end else begin
          slot = q_head[lk] + lqrm_pkg::SlotW'(q_count[lk]);
          waiters[lk][slot] = cl;
          q_count[lk]++;
          acq_status[cl] = (q_count[lk] > 1);
          // second waiter: revoke the holder
          if (q_count[lk] == 2) revoke_rec = new_callback(id, lk, waiters[lk][q_head[lk]]);
        end
      end
      if (id == acq_seen[cl]) begin
        st = acq_status[cl];
        if (revoke_rec.valid && revoke_rec.req == id && primary_q)
          push_callback(lqrm_pkg::MSG_REVOKE, revoke_rec);
      end
      // stale numbers fall through with status OK
      push_msg(lqrm_pkg::MSG_REPLY, st, cl, lk, 32'd0, 1'b1);
    end else begin
      if (rel_seen[cl] < id) begin
        rel_seen[cl] = id;
        if (q_count[lk] > 0) begin
          q_head[lk] = q_head[lk] + 1'b1;
          q_count[lk]--;
          if (q_count[lk] > 0) begin
            retry_rec = new_callback(id, lk, waiters[lk][q_head[lk]]);
            if (q_count[lk] > 1) revoke_rec = new_callback(id, lk, waiters[lk][q_head[lk]]);
          end
        end
      end
      if (rel_seen[cl] == id && primary_q) begin
        if (retry_rec.valid && retry_rec.req == id)
          push_callback(lqrm_pkg::MSG_RETRY, retry_rec);
        if (revoke_rec.valid && revoke_rec.req == id)
          push_callback(lqrm_pkg::MSG_REVOKE, revoke_rec);
      end
      push_msg(lqrm_pkg::MSG_REPLY, 1'b0, cl, lk, 32'd0, 1'b1);
    end
  endfunction

  // One request beat; prediction happens at the accepting edge.
  task automatic send_req(logic kind, logic [5:0] lk, logic [3:0] cl, logic [31:0] id);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'd0, id, cl, lk};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(kind, lk, cl, id);
    reqs_sent++;
  endtask

  function automatic logic [31:0] fresh_id(logic [3:0] cl);
    id_ctr[cl] = id_ctr[cl] + 32'd1;
    return id_ctr[cl];
  endfunction

  // Wait for every expected beat, then change the primary flag while idle.
  task automatic drain_and_config(logic primary);
    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= primary;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    primary_q = primary;
  endtask

  // Holder alone gets OK; second waiter revokes it; hand-off release; duplicates, stale ids and empty-queue release.
  task automatic test_contention();
    logic [31:0] a, r;
    send_req(lqrm_pkg::KIND_ACQ, 6'd1, 4'd0, fresh_id(4'd0));
    a = fresh_id(4'd1);
    send_req(lqrm_pkg::KIND_ACQ, 6'd1, 4'd1, a);
    send_req(lqrm_pkg::KIND_ACQ, 6'd1, 4'd1, a);           // duplicate acquire
    send_req(lqrm_pkg::KIND_ACQ, 6'd1, 4'd1, a - 32'd1);   // stale acquire
    send_req(lqrm_pkg::KIND_ACQ, 6'd1, 4'd2, fresh_id(4'd2));
    r = fresh_id(4'd0);
    send_req(lqrm_pkg::KIND_REL, 6'd1, 4'd0, r);           // hand-off, retry and revoke
    send_req(lqrm_pkg::KIND_REL, 6'd1, 4'd0, r);           // duplicate release
    send_req(lqrm_pkg::KIND_REL, 6'd1, 4'd0, r - 32'd1);   // stale release
    send_req(lqrm_pkg::KIND_REL, 6'd5, 4'd3, fresh_id(4'd3)); // release on empty queue
  endtask

  // Fill one lock's queue, then one more acquire is refused.
  task automatic test_full_queue();
    for (int c = 0; c < lqrm_pkg::NumClients; c++)
      send_req(lqrm_pkg::KIND_ACQ, 6'd2, 4'(c), fresh_id(4'(c)));
    send_req(lqrm_pkg::KIND_ACQ, 6'd2, 4'd4, fresh_id(4'd4));
  endtask

  // Extreme field values; client 15 is saturated afterwards.
  task automatic test_field_extremes();
    send_req(lqrm_pkg::KIND_ACQ, 6'd63, 4'd15, 32'hFFFF_FFFF);
    send_req(lqrm_pkg::KIND_REL, 6'd63, 4'd15, 32'hFFFF_FFFF);
    send_req(lqrm_pkg::KIND_ACQ, 6'd0, 4'd14, 32'd0);
    id_ctr[15] = 32'hFFFF_FFF0;
  endtask

  // Mostly fresh ids on a few hot locks, some duplicates, stale ids and jumps.
  task automatic test_random_traffic(int n);
    logic [3:0]  cl;
    logic [5:0]  lk;
    logic        kind;
    logic [31:0] id;
    int          pick;
    for (int i = 0; i < n; i++) begin
      cl   = 4'($urandom_range(15));
      lk   = ($urandom_range(9) < 8) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
      kind = ($urandom_range(99) < 55) ? lqrm_pkg::KIND_ACQ : lqrm_pkg::KIND_REL;
      pick = $urandom_range(99);
      if (pick < 80) begin
        id_ctr[cl] = id_ctr[cl] + 32'($urandom_range(1, 3));
        id = id_ctr[cl];
      end else if (pick < 88) begin
        id = id_ctr[cl];
      end else if (pick < 94) begin
        id = id_ctr[cl] - 32'($urandom_range(1, 5));
      end else begin
        id_ctr[cl] = $urandom;
        id = id_ctr[cl];
      end
      send_req(kind, lk, cl, id);
    end
  endtask

  // Result beat checker
  always @(posedge clk_i) begin
    lqrm_pkg::msg_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata[42:0], m_axis_tuser};
      beats_seen++;
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected beat %h", $realtime, got);
        fails++;
      end else begin
        want = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        if (got.msg_kind != want.msg_kind || got.reply_status != want.reply_status ||
            got.target_client != want.target_client || got.msg_lock != want.msg_lock ||
            got.call_seq != want.call_seq || got.last != want.last) begin
          $display("%0t: mismatch exp kind=%0d st=%0d tgt=%0d lock=%0d seq=%0d last=%0d",
                   $realtime, want.msg_kind, want.reply_status, want.target_client,
                   want.msg_lock, want.call_seq, want.last);
          $display("%0t:          act kind=%0d st=%0d tgt=%0d lock=%0d seq=%0d last=%0d",
                   $realtime, got.msg_kind, got.reply_status, got.target_client,
                   got.msg_lock, got.call_seq, got.last);
          fails++;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i)
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    primary_q = 1'b1;
    for (int c = 0; c < lqrm_pkg::NumClients; c++) begin
      acq_seen[c] = '0; acq_status[c] = 1'b0; rel_seen[c] = '0;
      cb_count[c] = 32'd1; id_ctr[c] = 32'd10;
    end
    for (int l = 0; l < lqrm_pkg::NumLocks; l++) begin
      q_head[l] = '0; q_count[l] = 0;
    end
    retry_rec  = '{default: '0};
    revoke_rec = '{default: '0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drain_and_config(1'b1);
    test_contention();
    test_full_queue();
    test_field_extremes();

    // four random phases (plain, idle, stall, idle and stall), primary flag toggled between them
    drain_and_config(1'b0);
    test_random_traffic(50);
    drain_and_config(1'b1);
    idle_pct = 49;
    test_random_traffic(50);
    drain_and_config(1'b0);
    idle_pct = 0; stall_pct = 49;
    test_random_traffic(50);
    drain_and_config(1'b1);
    idle_pct = 19; stall_pct = 19;
    test_random_traffic(50);

    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests and %0d result beats: contention, hand-off, full queue,",
             reqs_sent, beats_seen);
    $display("duplicate and stale ids, primary on and off, with idle and stall phases.");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
